FILE: src/battery_charge_refill_ntc_manager_unit_defines.svh
// Assertion macros for the charge supervisor.
// Used by the top level; no other dependencies.
`ifndef BATTERY_CHARGE_REFILL_NTC_MANAGER_UNIT_DEFINES_SVH
`define BATTERY_CHARGE_REFILL_NTC_MANAGER_UNIT_DEFINES_SVH

// same-cycle implication, reset gated
`define BCRN_ASSERT_NOW(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset gated
`define BCRN_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/bcrn_pkg.sv
// Shared types and codes for the charge supervisor.
// No dependencies.
package bcrn_pkg;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;

	// charger status codes
	localparam logic [1:0] ST_UNPLUGGED = 2'd0;
	localparam logic [1:0] ST_CHARGING  = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// full phase codes
	localparam logic [1:0] PH_NOT_FULL = 2'd0;
	localparam logic [1:0] PH_FULL     = 2'd1;
	localparam logic [1:0] PH_REFILL   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REFILL_MV    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_HIGH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_LOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESUME_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RESUME_LOW   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_LIMIT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CUR_LIMIT    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_GUARD_ENABLE = 3'd7;

	// current count clears on multiples of this refill tick count
	localparam int unsigned CLEAR_PERIOD = 20;
	localparam int unsigned MOD_W        = 5;

	typedef struct packed {
		logic [12:0]        refill_mv;
		logic signed [7:0]  stop_high;
		logic signed [7:0]  stop_low;
		logic signed [7:0]  resume_high;
		logic signed [7:0]  resume_low;
		logic [15:0]        tick_limit;
		logic [15:0]        cur_limit;
		logic               guard_en;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [12:0]        mv;
		logic signed [7:0]  temp;
		logic               cur;
	} item_t;

	typedef struct packed {
		logic       enable;
		logic [1:0] phase;
		logic       tstop;
	} result_t;

	typedef struct packed {
		logic             enable;
		logic [1:0]       phase;
		logic             tstop;
		logic [15:0]      ticks;
		logic [15:0]      cur_ticks;
		logic [MOD_W-1:0] tick_mod;
	} state_t;

endpackage

FILE: src/bcrn_cfg_regs.sv
// Configuration register file of the charge supervisor.
// Depends on bcrn_pkg.
module bcrn_cfg_regs import bcrn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.refill_mv   <= 13'd4100;
			cfg_q.stop_high   <= 8'sd45;
			cfg_q.stop_low    <= 8'sd0;
			cfg_q.resume_high <= 8'sd43;
			cfg_q.resume_low  <= 8'sd2;
			cfg_q.tick_limit  <= 16'd240;
			cfg_q.cur_limit   <= 16'd10;
			cfg_q.guard_en    <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_REFILL_MV:    cfg_q.refill_mv   <= wr_data[12:0];
				REG_STOP_HIGH:    cfg_q.stop_high   <= wr_data[7:0];
				REG_STOP_LOW:     cfg_q.stop_low    <= wr_data[7:0];
				REG_RESUME_HIGH:  cfg_q.resume_high <= wr_data[7:0];
				REG_RESUME_LOW:   cfg_q.resume_low  <= wr_data[7:0];
				REG_TICK_LIMIT:   cfg_q.tick_limit  <= wr_data[15:0];
				REG_CUR_LIMIT:    cfg_q.cur_limit   <= wr_data[15:0];
				REG_GUARD_ENABLE: cfg_q.guard_en    <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/bcrn_ctrl.sv
// Supervision state and its next-state logic for one tick.
// Depends on bcrn_pkg.
module bcrn_ctrl import bcrn_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    commit,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res_next,
	output state_t  state
);

	state_t st_q;
	state_t st_d;
	logic [15:0] ticks_inc;
	logic [MOD_W-1:0] mod_inc;
	logic stop_hit;

	always_comb begin
		st_d      = st_q;
		ticks_inc = st_q.ticks + 16'd1;
		// tick_mod tracks ticks mod 20, including the 16-bit wrap
		if (ticks_inc == 16'd0 || st_q.tick_mod == MOD_W'(CLEAR_PERIOD - 1))
			mod_inc = '0;
		else
			mod_inc = st_q.tick_mod + MOD_W'(1);
		stop_hit = (item.temp > cfg.stop_high) || (item.temp < cfg.stop_low);

		case (item.status)
			ST_UNPLUGGED: begin
				st_d.phase  = PH_NOT_FULL;
				st_d.tstop  = 1'b0;
				st_d.enable = 1'b1;
			end
			ST_CHARGING: begin
				if (cfg.guard_en) begin
					if (!st_q.tstop && stop_hit) begin
						st_d.tstop  = 1'b1;
						st_d.enable = 1'b0;
					end
					// resume test sees the flag as just updated
					if (st_d.tstop && item.temp < cfg.resume_high &&
					    item.temp > cfg.resume_low) begin
						st_d.tstop  = 1'b0;
						st_d.enable = 1'b1;
					end
				end
			end
			ST_FULL: begin
				st_d.tstop = 1'b0;
				if (st_q.phase == PH_NOT_FULL) begin
					st_d.phase  = PH_FULL;
					st_d.enable = 1'b0;
				end else if (st_q.phase == PH_FULL) begin
					if (item.mv < cfg.refill_mv) begin
						st_d.phase     = PH_REFILL;
						st_d.ticks     = '0;
						st_d.cur_ticks = '0;
						st_d.tick_mod  = '0;
						st_d.enable    = 1'b1;
					end
				end else begin
					st_d.ticks    = ticks_inc;
					st_d.tick_mod = mod_inc;
					if (item.cur)
						st_d.cur_ticks = st_q.cur_ticks + 16'd1;
					else if (mod_inc == '0)
						st_d.cur_ticks = '0;
					if (st_d.ticks > cfg.tick_limit || st_d.cur_ticks > cfg.cur_limit) begin
						st_d.phase  = PH_FULL;
						st_d.enable = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.enable    <= 1'b1;
			st_q.phase     <= PH_NOT_FULL;
			st_q.tstop     <= 1'b0;
			st_q.ticks     <= '0;
			st_q.cur_ticks <= '0;
			st_q.tick_mod  <= '0;
		end else if (commit) begin
			st_q <= st_d;
		end
	end

	assign res_next.enable = st_d.enable;
	assign res_next.phase  = st_d.phase;
	assign res_next.tstop  = st_d.tstop;
	assign state           = st_q;

endmodule

FILE: src/battery_charge_refill_ntc_manager_unit.sv
// Top level of the charge supervisor: input register, state update, result register.
// Depends on bcrn_pkg, bcrn_cfg_regs, bcrn_ctrl and the assertion macro header.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | input     | in_valid/in_stall  | charger_status, battery_millivolts, ...
//  out     | output    | out_valid/out_stall| charger_enable, full_phase, thermal_stopped
//  config  | input     | wr_en              | wr_index, wr_data
//
// One beat per cycle sustained while out_stall is low; a tick taken into the input
// register moves on into the result register and is offered at the output from there.
// A tick passes through the input register and the result register; the state update
// happens as a tick moves from one to the other.
// Reset restores the register defaults and the charger-on state; no clearing pass.
// A stalled result holds; the input side stalls only when both registers are full
// and the result is stalled.
`include "battery_charge_refill_ntc_manager_unit_defines.svh"

module battery_charge_refill_ntc_manager_unit import bcrn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            charger_status,
	input  logic [12:0]           battery_millivolts,
	input  logic signed [7:0]     temperature,
	input  logic                  current_present,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  charger_enable,
	output logic [1:0]            full_phase,
	output logic                  thermal_stopped,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t res_next;
	state_t  state;
	logic    advance;
	logic    accept;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	bcrn_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	bcrn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (advance),
		.item     (item_s1),
		.cfg      (cfg),
		.res_next (res_next),
		.state    (state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.status <= charger_status;
			item_s1.mv     <= battery_millivolts;
			item_s1.temp   <= temperature;
			item_s1.cur    <= current_present;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_next;
	end

	assign out_valid       = valid_s2;
	assign charger_enable  = res_s2.enable;
	assign full_phase      = res_s2.phase;
	assign thermal_stopped = res_s2.tstop;

	`BCRN_ASSERT_NOW(a_tstop_off, clk, arst_n, state.tstop, !state.enable, "thermal stop with charger on")
	`BCRN_ASSERT_NOW(a_mod_track, clk, arst_n, 1'b1, state.tick_mod == MOD_W'(state.ticks % CLEAR_PERIOD), "refill tick phase out of step")
	`BCRN_ASSERT_NEXT(a_adv_out, clk, arst_n, advance, valid_s2, "advanced tick missing at output")
	`BCRN_ASSERT_NOW(a_stall_full, clk, arst_n, in_stall, valid_s1 && valid_s2 && out_stall, "input stalled with room")

endmodule
